// ----- sv/ret_pkg.sv -----
package ret_pkg;
    localparam int unsigned ENTRIES_DEF = 64;
    localparam logic [25:0] PURGE_FACTOR = 26'd4;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_CHECK  = 3'd1,
        OP_PURGE  = 3'd2,
        OP_REMOVE = 3'd3,
        OP_UPDATE = 3'd4
    } t_op;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] job_key;
        logic [31:0] host_key;
        logic [31:0] time_value;
        logic [15:0] queue_limit;
        logic        limit_off;
        logic [23:0] retry_window;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic       hold_back;
        logic [6:0] remaining;
        logic       host_clear;
    } t_out;

    // memory word of one slot
    typedef struct packed {
        logic [31:0] job;
        logic [31:0] host;
        logic [31:0] rtime;
        logic [15:0] queued;
        logic        in_use;
    } t_entry;
endpackage

// ----- sv/ret_mem.sv -----
module ret_mem #(
    parameter int unsigned ENTRIES = ret_pkg::ENTRIES_DEF,
    localparam int unsigned AW = $clog2(ENTRIES)
) (
    input  logic            i_clk,
    input  logic [AW-1:0]   i_raddr,
    output ret_pkg::t_entry o_rdata,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ret_pkg::t_entry i_wdata
);
    ret_pkg::t_entry mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ----- sv/retry_error_table.sv -----
// Retry error table: failed jobs awaiting retry.
// Command channel: drive i_cmd and pulse i_start while o_busy is low; the
// transfer happens at that edge. o_busy stays high until the result is shown.
// Result channel: o_done is high for one cycle with o_result valid; the
// receiver must take it, there is no stall.
// Each command scans the entry memory one slot per cycle over its single read
// port: one pass issues a read of every slot, waits for the registered read
// data and drains before it ends. Check, remove, update and add run a lookup
// pass and then the write-back state; a found remove then runs a host pass;
// purge runs only the host pass. Every command ends in S_OUT, which raises
// o_done. o_busy drops in the cycle o_done is high, so the next transfer
// may share that edge; one command is in flight at a time.
// Add picks the lowest free slot from the valid flip-flops in the write-back
// cycle. The write port is used only in the write-back cycle; purge and remove
// clear valid flip-flops only.
// Reset clears the valid bits in flip-flops at once; no clearing pass.
module retry_error_table #(
    parameter int unsigned ENTRIES = ret_pkg::ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ret_pkg::t_in  i_cmd,
    output logic          o_busy,
    output logic          o_done,
    output ret_pkg::t_out o_result
);
    localparam int unsigned AW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FIND = 5'b00010,
        S_HOST = 5'b00100,
        S_WB   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    ret_pkg::t_in    r_cmd, n_cmd;
    logic [CW-1:0]   r_idx, n_idx;     // address issued
    logic            r_rv, n_rv;       // read data on rdata valid
    logic [AW-1:0]   r_ridx, n_ridx;   // address of data on rdata
    logic            r_found, n_found;
    logic [AW-1:0]   r_slot, n_slot;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [6:0]      r_cnt, n_cnt;
    ret_pkg::t_out   r_res, n_res;
    logic            r_done, n_done;
    ret_pkg::t_entry r_ent, n_ent;

    logic            we;
    logic [AW-1:0]   waddr;
    ret_pkg::t_entry wdata, rdata;

    ret_mem #(.ENTRIES(ENTRIES)) u_mem (
        .i_clk  (i_clk),
        .i_raddr(r_idx[AW-1:0]),
        .o_rdata(rdata),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata)
    );

    logic        last;
    logic        hit_job, hit_host;
    logic [32:0] rt_purge;
    logic [32:0] ent_win;

    always_comb begin
        last     = (r_idx == CW'(ENTRIES));
        hit_job  = r_rv && r_valid[r_ridx] && rdata.job == r_cmd.job_key;
        hit_host = r_rv && r_valid[r_ridx] && rdata.host == r_cmd.host_key;
        rt_purge = {1'b0, rdata.rtime} + 33'({r_cmd.retry_window, 2'b00});
        ent_win  = {1'b0, r_ent.rtime} + 33'(r_cmd.retry_window);
        n_state = r_state;
        n_cmd   = r_cmd;
        n_idx   = r_idx;
        n_rv    = 1'b0;
        n_ridx  = r_idx[AW-1:0];
        n_found = r_found;
        n_slot  = r_slot;
        n_valid = r_valid;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_done  = 1'b0;
        n_ent   = r_ent;
        we      = 1'b0;
        waddr   = r_slot;
        wdata   = r_ent;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_cnt   = '0;
                    n_res   = '0;
                    n_state = (i_cmd.operation == ret_pkg::OP_PURGE) ? S_HOST : S_FIND;
                end
            end
            S_FIND: begin
                if (!last) begin
                    n_idx = r_idx + CW'(1);
                    n_rv  = 1'b1;
                end
                if (hit_job && !r_found) begin
                    n_found = 1'b1;
                    n_slot  = r_ridx;
                    n_ent   = rdata;
                end
                if (last && !r_rv) begin
                    n_state = S_WB;
                end
            end
            S_HOST: begin
                if (!last) begin
                    n_idx = r_idx + CW'(1);
                    n_rv  = 1'b1;
                end
                if (hit_host) begin
                    if (r_cmd.operation == ret_pkg::OP_PURGE
                            && rt_purge < {1'b0, r_cmd.time_value}) begin
                        n_valid[r_ridx] = 1'b0;
                    end else if (r_cnt != 7'd127) begin
                        n_cnt = r_cnt + 7'd1;
                    end
                end
                if (last && !r_rv) begin
                    n_res.remaining  = (r_cmd.operation == ret_pkg::OP_PURGE) ? r_cnt : 7'd0;
                    n_res.host_clear = (r_cmd.operation == ret_pkg::OP_REMOVE)
                                       && (r_cnt == 7'd0);
                    n_state = S_OUT;
                end
            end
            S_WB: begin
                n_state = S_OUT;
                unique case (r_cmd.operation)
                    ret_pkg::OP_ADD: begin
                        if (r_found) begin
                            we = 1'b1;
                            wdata.rtime = r_cmd.time_value;
                        end else if (&r_valid) begin
                            n_res.status = ret_pkg::ST_FULL;
                        end else begin
                            // lowest free slot
                            for (int i = ENTRIES - 1; i >= 0; i--) begin
                                if (!r_valid[i]) waddr = AW'(i);
                            end
                            we = 1'b1;
                            wdata = '{r_cmd.job_key, r_cmd.host_key,
                                      r_cmd.time_value, 16'd0, 1'b0};
                            n_valid[waddr] = 1'b1;
                        end
                    end
                    ret_pkg::OP_CHECK: begin
                        if (!r_found) begin
                            n_res.status = ret_pkg::ST_NOT_FOUND;
                        end else if (r_cmd.limit_off || r_ent.queued >= r_cmd.queue_limit) begin
                            if (r_cmd.time_value == 32'd0 || r_cmd.time_value < r_ent.rtime) begin
                                n_res.hold_back = 1'b1;
                            end else if (r_ent.in_use) begin
                                n_res.hold_back = {1'b0, r_cmd.time_value} < ent_win;
                            end else begin
                                we = 1'b1;
                                wdata.in_use = 1'b1;
                            end
                        end else begin
                            we = 1'b1;
                            wdata.queued = r_ent.queued + 16'd1;
                        end
                    end
                    ret_pkg::OP_REMOVE: begin
                        if (!r_found) begin
                            n_res.status = ret_pkg::ST_NOT_FOUND;
                        end else begin
                            n_valid[r_slot] = 1'b0;
                            n_idx   = '0;
                            n_state = S_HOST;
                        end
                    end
                    ret_pkg::OP_UPDATE: begin
                        if (!r_found) begin
                            n_res.status = ret_pkg::ST_NOT_FOUND;
                        end else begin
                            we = 1'b1;
                            wdata.rtime  = r_cmd.time_value;
                            wdata.in_use = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_OUT: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_done  <= 1'b0;
            r_rv    <= 1'b0;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_done  <= n_done;
            r_rv    <= n_rv;
            r_idx   <= n_idx;
            r_found <= n_found;
            r_cnt   <= n_cnt;
        end
        r_cmd  <= n_cmd;
        r_ridx <= n_ridx;
        r_slot <= n_slot;
        r_res  <= n_res;
        r_ent  <= n_ent;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

// ----- tb/sv/retry_error_table_checker.sv -----
module retry_error_table_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  ret_pkg::t_in  i_cmd,
    input  logic          i_done,
    input  ret_pkg::t_out i_result,
    output int            o_errors,
    output int            o_pending
);
    localparam int N = ret_pkg::ENTRIES_DEF;

    logic        slot_valid [N];
    logic [31:0] slot_job [N];
    logic [31:0] slot_host [N];
    logic [31:0] slot_rtime [N];
    logic [15:0] slot_queued [N];
    logic        slot_in_use [N];

    ret_pkg::t_out expected_results[$];
    int   err_cnt;

    assign o_errors  = err_cnt;
    assign o_pending = expected_results.size();

    function automatic int find_slot(logic [31:0] job);
        for (int i = 0; i < N; i++) begin
            if (slot_valid[i] && slot_job[i] == job) return i;
        end
        return -1;
    endfunction

    task automatic apply_command(input ret_pkg::t_in c, output ret_pkg::t_out r);
        int k;
        int i;
        logic [32:0] sum;
        logic [33:0] psum;
        r = '0;
        case (c.operation)
            ret_pkg::OP_ADD: begin
                k = find_slot(c.job_key);
                if (k >= 0) begin
                    slot_rtime[k] = c.time_value;
                end else begin
                    i = 0;
                    while (i < N && slot_valid[i]) i++;
                    if (i >= N) begin
                        r.status = ret_pkg::ST_FULL;
                    end else begin
                        slot_valid[i]  = 1'b1;
                        slot_job[i]    = c.job_key;
                        slot_host[i]   = c.host_key;
                        slot_rtime[i]  = c.time_value;
                        slot_queued[i] = '0;
                        slot_in_use[i] = 1'b0;
                    end
                end
            end
            ret_pkg::OP_CHECK: begin
                k = find_slot(c.job_key);
                if (k < 0) begin
                    r.status = ret_pkg::ST_NOT_FOUND;
                end else if (c.limit_off || slot_queued[k] >= c.queue_limit) begin
                    sum = {1'b0, slot_rtime[k]} + {9'd0, c.retry_window};
                    if (c.time_value == 0 || c.time_value < slot_rtime[k])
                        r.hold_back = 1'b1;
                    else if (slot_in_use[k])
                        r.hold_back = ({1'b0, c.time_value} < sum);
                    else
                        slot_in_use[k] = 1'b1;
                end else begin
                    slot_queued[k] = slot_queued[k] + 16'd1;
                end
            end
            ret_pkg::OP_PURGE: begin
                for (int j = 0; j < N; j++) begin
                    if (slot_valid[j] && slot_host[j] == c.host_key) begin
                        psum = {2'b0, slot_rtime[j]} + {8'd0, c.retry_window, 2'b00};
                        if (psum < {2'b0, c.time_value}) slot_valid[j] = 1'b0;
                        else if (r.remaining < 7'd127) r.remaining = r.remaining + 7'd1;
                    end
                end
            end
            ret_pkg::OP_REMOVE: begin
                k = find_slot(c.job_key);
                if (k < 0) begin
                    r.status = ret_pkg::ST_NOT_FOUND;
                end else begin
                    slot_valid[k] = 1'b0;
                    r.host_clear = 1'b1;
                    for (int j = 0; j < N; j++) begin
                        if (slot_valid[j] && slot_host[j] == c.host_key) r.host_clear = 1'b0;
                    end
                end
            end
            ret_pkg::OP_UPDATE: begin
                k = find_slot(c.job_key);
                if (k < 0) begin
                    r.status = ret_pkg::ST_NOT_FOUND;
                end else begin
                    slot_rtime[k]  = c.time_value;
                    slot_in_use[k] = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        ret_pkg::t_out r;
        ret_pkg::t_out e;
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) slot_valid[i] = 1'b0;
            expected_results.delete();
            err_cnt = 0;
        end else begin
            // a result may land on the same edge as the next transfer; compare first
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) $display("unexpected result %p", i_result);
                end else begin
                    e = expected_results.pop_front();
                    if (e !== i_result) begin
                        err_cnt++;
                        if (err_cnt <= 10) $display("expected %p got %p", e, i_result);
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_command(i_cmd, r);
                expected_results.push_back(r);
            end
        end
    end
endmodule

// ----- tb/sv/retry_error_table_test.sv -----
module retry_error_table_test;
    logic  i_clk;
    logic  i_rst_n;
    logic  i_start;
    ret_pkg::t_in   i_cmd;
    logic  o_busy;
    logic  o_done;
    ret_pkg::t_out  o_result;
    int    errors;
    int    pending;
    int    idle_cycles;
    logic [31:0] job_pool [16];
    logic [31:0] host_pool [4];

    retry_error_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .o_busy(o_busy), .o_done(o_done), .o_result(o_result)
    );

    retry_error_table_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_cmd(i_cmd), .i_done(o_done), .i_result(o_result),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: cycles without any transfer or result
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("retry_error_table: mismatch");
            $finish;
        end
    end

    task automatic send(input ret_pkg::t_in c);
        @(negedge i_clk);
        i_cmd   <= c;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    function automatic ret_pkg::t_in mk(ret_pkg::t_op op, logic [31:0] job,
                                        logic [31:0] host, logic [31:0] tv,
                                        logic [15:0] ql, logic lo,
                                        logic [23:0] win);
        ret_pkg::t_in c;
        c.operation = op; c.job_key = job; c.host_key = host; c.time_value = tv;
        c.queue_limit = ql; c.limit_off = lo; c.retry_window = win;
        return c;
    endfunction

    function automatic ret_pkg::t_in rand_cmd();
        ret_pkg::t_in c;
        int sel;
        c.operation    = $urandom_range(0, 99) < 3 ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
        sel = $urandom_range(0, 9);
        c.job_key      = sel == 0 ? $urandom() : job_pool[$urandom_range(0, 15)];
        c.host_key     = sel == 1 ? $urandom() : host_pool[$urandom_range(0, 3)];
        case ($urandom_range(0, 3))
            0: c.time_value = $urandom();
            1: c.time_value = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'd0;
            default: c.time_value = 32'h8000_0000 + $urandom_range(0, 4000) - 2000;
        endcase
        c.queue_limit  = $urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 3));
        c.limit_off    = $urandom_range(0, 1);
        c.retry_window = $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 600));
        return c;
    endfunction

    initial begin
        int burst;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd   = '0;
        for (int i = 0; i < 16; i++) job_pool[i] = i < 2 ? (i == 0 ? 32'd0 : 32'hFFFF_FFFF) : $urandom();
        for (int i = 0; i < 4; i++) host_pool[i] = i == 0 ? 32'hFFFF_FFFF : $urandom();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send(mk(ret_pkg::OP_CHECK, 32'd5, 0, 10, 0, 0, 0));
        send(mk(ret_pkg::OP_REMOVE, 32'd5, 0, 0, 0, 0, 0));
        send(mk(ret_pkg::OP_UPDATE, 32'd5, 0, 0, 0, 0, 0));
        send(mk(ret_pkg::OP_ADD, 32'd0, 32'd0, 32'hFFFF_FFFF, 0, 0, 0));
        send(mk(ret_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100, 0, 0, 0));
        send(mk(ret_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd50, 0, 0, 0));
        send(mk(ret_pkg::OP_CHECK, 32'hFFFF_FFFF, 0, 60, 16'hFFFF, 0, 24'hFFFFFF));
        send(mk(ret_pkg::OP_CHECK, 32'hFFFF_FFFF, 0, 0, 0, 1, 24'hFFFFFF));
        send(mk(ret_pkg::OP_CHECK, 32'hFFFF_FFFF, 0, 40, 0, 1, 0));
        send(mk(ret_pkg::OP_CHECK, 32'hFFFF_FFFF, 0, 60, 0, 1, 10));
        send(mk(ret_pkg::OP_CHECK, 32'hFFFF_FFFF, 0, 59, 0, 1, 10));
        send(mk(ret_pkg::OP_CHECK, 32'hFFFF_FFFF, 0, 60, 0, 1, 10));
        send(mk(ret_pkg::OP_CHECK, 32'd0, 0, 32'hFFFF_FFFF, 0, 0, 24'hFFFFFF));
        send(mk(ret_pkg::OP_UPDATE, 32'hFFFF_FFFF, 0, 32'd1000, 0, 0, 0));
        send(mk(ret_pkg::OP_PURGE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 24'hFFFFFF));
        send(mk(ret_pkg::OP_PURGE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
        send(mk(ret_pkg::OP_REMOVE, 32'd0, 32'd0, 0, 0, 0, 0));
        send(mk(ret_pkg::t_op'(3'd7), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                16'hFFFF, 1, 24'hFFFFFF));
        // fill to full, overflow, then drain by purge
        for (int i = 0; i < 66; i++) send(mk(ret_pkg::OP_ADD, 32'h1000 + i, 32'h77, i, 0, 0, 0));
        send(mk(ret_pkg::OP_PURGE, 0, 32'h77, 32'd30, 0, 0, 24'd1));
        send(mk(ret_pkg::OP_PURGE, 0, 32'h77, 32'hFFFF_FFFF, 0, 0, 0));

        for (int n = 0; n < 1750; n += burst) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++) send(rand_cmd());
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 150)) @(negedge i_clk);
        end

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("retry_error_table: match");
        else $display("retry_error_table: mismatch");
        $finish;
    end
endmodule
